// ===== design/jctp_pkg.sv =====
// Shared types, constants and reciprocal tables for the JC69 transition
// probability pipeline. No dependencies.
`default_nettype none

package jctp_pkg;

  localparam int DIST_FRAC_BITS_DEF = 16;
  localparam int OUT_FRAC_BITS_DEF  = 30;

  localparam int DIST_W = 24;
  localparam int OUT_W  = 32;

  localparam logic [32:0] Q32_ONE = 33'h1_0000_0000;
  localparam logic [31:0] LN2_Q32 = 32'hB172_17F8;

  // range-reduction width: x below 32*ln2 fits in 37 bits
  localparam int                RED_W     = 37;
  localparam int                N_W       = 5;
  localparam logic [RED_W-1:0] UFLOW_LIM = 37'h16_2E42_FF00;

  localparam int POLY_TERMS  = 12;
  localparam int POLY_STAGES = 2 * POLY_TERMS;

  localparam int FRONT_STAGES = 2;
  localparam int OUT_STAGES   = 5;
  localparam int PIPE_LATENCY = FRONT_STAGES + N_W + POLY_STAGES + OUT_STAGES;

  typedef enum logic [1:0] {
    MODE_PROB   = 2'd0,
    MODE_DERIV1 = 2'd1,
    MODE_DERIV2 = 2'd2,
    MODE_UNUSED = 2'd3
  } mode_t;

  typedef struct packed {
    mode_t          mode;
    logic           diag;
    logic           uflow;
    logic [N_W-1:0] n;
  } side_t;

  // ceil(2^(32+l)/k), l = ceil(log2 k): exact floor(t/k) for 32-bit t
  function automatic logic [32:0] poly_recip(input int k);
    logic [32:0] m;
    case (k)
      1:       m = 33'd4294967296;
      2:       m = 33'd4294967296;
      3:       m = 33'd5726623062;
      4:       m = 33'd4294967296;
      5:       m = 33'd6871947674;
      6:       m = 33'd5726623062;
      7:       m = 33'd4908534053;
      8:       m = 33'd4294967296;
      9:       m = 33'd7635497416;
      10:      m = 33'd6871947674;
      11:      m = 33'd6247225158;
      12:      m = 33'd5726623062;
      default: m = 33'd4294967296;
    endcase
    return m;
  endfunction

  function automatic int poly_log(input int k);
    int l;
    case (k)
      1:       l = 0;
      2:       l = 1;
      3:       l = 2;
      4:       l = 2;
      5:       l = 3;
      6:       l = 3;
      7:       l = 3;
      8:       l = 3;
      default: l = 4;
    endcase
    return l;
  endfunction

endpackage

`default_nettype wire

// ===== design/jukes_cantor_transition_prob.sv =====
// JC69 transition probability and derivatives, one item per clock.
// Pipeline: 2 scaling, 5 range-reduction, 24 Horner and 5 output stages.
// Throughput: one item every cycle; busy is always low, results cannot stall.
// Reset clears the stage valid bits only. Depends on jctp_pkg and submodules.
`default_nettype none

module jukes_cantor_transition_prob #(
  parameter int DIST_FRAC_BITS = jctp_pkg::DIST_FRAC_BITS_DEF,
  parameter int OUT_FRAC_BITS  = jctp_pkg::OUT_FRAC_BITS_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              start,
  output logic                              busy,
  input  logic [1:0]                        in_mode,
  input  logic [1:0]                        in_from_base,
  input  logic [1:0]                        in_to_base,
  input  logic [jctp_pkg::DIST_W-1:0]       in_branch_length,
  output logic                              out_valid,
  output logic signed [jctp_pkg::OUT_W-1:0] out_value
);
  import jctp_pkg::*;

  logic             fr_valid;
  side_t            fr_side;
  logic [RED_W-1:0] fr_red;
  logic             rg_valid;
  side_t            rg_side;
  logic [31:0]      rg_r;
  logic             pl_valid;
  side_t            pl_side;
  logic [32:0]      pl_p;

  assign busy = 1'b0;

  jctp_front #(
    .DIST_FRAC_BITS (DIST_FRAC_BITS)
  ) u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (start & ~busy),
    .in_mode      (in_mode),
    .in_from_base (in_from_base),
    .in_to_base   (in_to_base),
    .in_dist      (in_branch_length),
    .out_valid    (fr_valid),
    .out_side     (fr_side),
    .out_red      (fr_red)
  );

  jctp_range u_range (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (fr_valid),
    .in_side   (fr_side),
    .in_red    (fr_red),
    .out_valid (rg_valid),
    .out_side  (rg_side),
    .out_r     (rg_r)
  );

  jctp_poly u_poly (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (rg_valid),
    .in_side   (rg_side),
    .in_r      (rg_r),
    .out_valid (pl_valid),
    .out_side  (pl_side),
    .out_p     (pl_p)
  );

  jctp_out #(
    .OUT_FRAC_BITS (OUT_FRAC_BITS)
  ) u_out (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (pl_valid),
    .in_side   (pl_side),
    .in_p      (pl_p),
    .out_valid (out_valid),
    .out_value (out_value)
  );

endmodule

`default_nettype wire

// ===== design/jctp_front.sv =====
// Front end: scales the distance to x = floor(4/3 * d) in Q.32 and flags
// exponent underflow. Depends on jctp_pkg.
`default_nettype none

module jctp_front #(
  parameter int DIST_FRAC_BITS = jctp_pkg::DIST_FRAC_BITS_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  input  logic [1:0]                     in_mode,
  input  logic [1:0]                     in_from_base,
  input  logic [1:0]                     in_to_base,
  input  logic [jctp_pkg::DIST_W-1:0]    in_dist,
  output logic                           out_valid,
  output jctp_pkg::side_t                out_side,
  output logic [jctp_pkg::RED_W-1:0]     out_red
);
  import jctp_pkg::*;

  // 4*dq = d << K
  localparam int K  = 34 - DIST_FRAC_BITS;
  localparam int XW = 24 + K;

  localparam logic [24:0]   DIV3_M  = 25'd22369622;
  localparam int            DIV3_SH = 26;
  localparam logic [XW-1:0] FRAC1   = XW'((64'd1 << K) / 64'd3);
  localparam logic [XW-1:0] FRAC2   = XW'((64'd1 << (K + 1)) / 64'd3);

  logic [48:0] prod3;
  logic [22:0] q3_nxt;
  logic [24:0] q3x3;
  logic [24:0] diff;
  side_t       side1_nxt;

  logic        s1_vld_r;
  side_t       s1_side_r;
  logic [22:0] s1_q3_r;
  logic [1:0]  s1_rem_r;

  logic [XW-1:0]    frac;
  logic [XW-1:0]    x;
  logic [63:0]      x64;
  side_t            side2_nxt;

  logic             s2_vld_r;
  side_t            s2_side_r;
  logic [RED_W-1:0] s2_red_r;

  always_comb begin
    prod3  = 49'(in_dist) * 49'(DIV3_M);
    q3_nxt = prod3[48:DIV3_SH];
    q3x3   = {2'b00, q3_nxt} + {1'b0, q3_nxt, 1'b0};
    diff   = {1'b0, in_dist} - q3x3;

    side1_nxt.mode  = mode_t'(in_mode);
    side1_nxt.diag  = (in_from_base == in_to_base);
    side1_nxt.uflow = 1'b0;
    side1_nxt.n     = '0;
  end

  always_comb begin
    case (s1_rem_r)
      2'd1:    frac = FRAC1;
      2'd2:    frac = FRAC2;
      default: frac = '0;
    endcase
    x   = (XW'(s1_q3_r) << K) + frac;
    x64 = 64'(x);

    side2_nxt       = s1_side_r;
    side2_nxt.uflow = (x64 >= 64'(UFLOW_LIM));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
      s2_vld_r <= 1'b0;
    end else begin
      s1_vld_r <= in_valid;
      s2_vld_r <= s1_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    s1_side_r <= side1_nxt;
    s1_q3_r   <= q3_nxt;
    s1_rem_r  <= diff[1:0];
    s2_side_r <= side2_nxt;
    s2_red_r  <= x64[RED_W-1:0];
  end

  assign out_valid = s2_vld_r;
  assign out_side  = s2_side_r;
  assign out_red   = s2_red_r;

endmodule

`default_nettype wire

// ===== design/jctp_range.sv =====
// Range reduction x = n*ln2 + r, one restoring quotient bit per stage.
// Depends on jctp_pkg.
`default_nettype none

module jctp_range (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  input  jctp_pkg::side_t             in_side,
  input  logic [jctp_pkg::RED_W-1:0]  in_red,
  output logic                        out_valid,
  output jctp_pkg::side_t             out_side,
  output logic [31:0]                 out_r
);
  import jctp_pkg::*;

  logic [N_W-1:0]   vld_r;
  logic [N_W-1:0]   vld_src;
  side_t            side_r   [N_W];
  side_t            side_src [N_W];
  side_t            side_nxt [N_W];
  logic [RED_W-1:0] red_r    [N_W];
  logic [RED_W-1:0] red_src  [N_W];
  logic [RED_W-1:0] red_nxt  [N_W];
  logic [RED_W-1:0] lim      [N_W];

  always_comb begin
    for (int i = 0; i < N_W; i++) begin
      if (i == 0) begin
        vld_src[i]  = in_valid;
        side_src[i] = in_side;
        red_src[i]  = in_red;
      end else begin
        vld_src[i]  = vld_r[i-1];
        side_src[i] = side_r[i-1];
        red_src[i]  = red_r[i-1];
      end
      lim[i]      = RED_W'(LN2_Q32) << (N_W - 1 - i);
      side_nxt[i] = side_src[i];
      red_nxt[i]  = red_src[i];
      if (red_src[i] >= lim[i]) begin
        red_nxt[i]                  = red_src[i] - lim[i];
        side_nxt[i].n[N_W - 1 - i] = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= vld_src;
    end
  end

  always_ff @(posedge clk) begin
    side_r <= side_nxt;
    red_r  <= red_nxt;
  end

  assign out_valid = vld_r[N_W-1];
  assign out_side  = side_r[N_W-1];
  assign out_r     = red_r[N_W-1][31:0];

endmodule

`default_nettype wire

// ===== design/jctp_poly.sv =====
// Horner evaluation of exp(-r), two stages per term: r*p, then the
// divide by k through a reciprocal multiply. Depends on jctp_pkg.
`default_nettype none

module jctp_poly (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  input  jctp_pkg::side_t  in_side,
  input  logic [31:0]      in_r,
  output logic             out_valid,
  output jctp_pkg::side_t  out_side,
  output logic [32:0]      out_p
);
  import jctp_pkg::*;

  logic [POLY_STAGES-1:0] vld_r;
  logic [POLY_STAGES-1:0] vld_src;
  side_t                  side_r   [POLY_STAGES];
  side_t                  side_src [POLY_STAGES];
  logic [31:0]            r_r      [POLY_STAGES];
  logic [31:0]            r_src    [POLY_STAGES];
  logic [32:0]            acc_r    [POLY_STAGES];
  logic [32:0]            acc_src  [POLY_STAGES];
  logic [32:0]            acc_nxt  [POLY_STAGES];

  logic [64:0] mul;
  logic [64:0] quo;
  int          k;

  always_comb begin
    mul = '0;
    quo = '0;
    k   = 1;
    for (int j = 0; j < POLY_STAGES; j++) begin
      if (j == 0) begin
        vld_src[j]  = in_valid;
        side_src[j] = in_side;
        r_src[j]    = in_r;
        acc_src[j]  = Q32_ONE;
      end else begin
        vld_src[j]  = vld_r[j-1];
        side_src[j] = side_r[j-1];
        r_src[j]    = r_r[j-1];
        acc_src[j]  = acc_r[j-1];
      end
      if ((j % 2) == 0) begin
        mul        = 65'(r_src[j]) * 65'(acc_src[j]);
        acc_nxt[j] = {1'b0, mul[63:32]};
      end else begin
        k          = POLY_TERMS - (j / 2);
        mul        = 65'(acc_src[j][31:0]) * 65'(poly_recip(k));
        quo        = mul >> (32 + poly_log(k));
        acc_nxt[j] = Q32_ONE - quo[32:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= vld_src;
    end
  end

  always_ff @(posedge clk) begin
    side_r <= side_src;
    r_r    <= r_src;
    acc_r  <= acc_nxt;
  end

  assign out_valid = vld_r[POLY_STAGES-1];
  assign out_side  = side_r[POLY_STAGES-1];
  assign out_p     = acc_r[POLY_STAGES-1];

endmodule

`default_nettype wire

// ===== design/jctp_out.sv =====
// Output stages: e = p >> n, mode/case selection, rounding to the output
// format and division by 1, 3, 4 or 9. Depends on jctp_pkg.
`default_nettype none

module jctp_out #(
  parameter int OUT_FRAC_BITS = jctp_pkg::OUT_FRAC_BITS_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  input  jctp_pkg::side_t                   in_side,
  input  logic [32:0]                       in_p,
  output logic                              out_valid,
  output logic signed [jctp_pkg::OUT_W-1:0] out_value
);
  import jctp_pkg::*;

  localparam int RS = 32 - OUT_FRAC_BITS;

  typedef enum logic [1:0] {
    DEN_1 = 2'd0,
    DEN_3 = 2'd1,
    DEN_4 = 2'd2,
    DEN_9 = 2'd3
  } den_t;

  localparam logic [33:0] RECIP_1 = 34'd8589934592;
  localparam logic [33:0] RECIP_3 = 34'd11453246123;
  localparam logic [33:0] RECIP_9 = 34'd15270994831;

  logic [32:0] e_nxt;
  logic        o1_vld_r;
  side_t       o1_side_r;
  logic [32:0] o1_e_r;

  logic [34:0] e35;
  logic [34:0] mag_nxt;
  den_t        den_nxt;
  logic        neg_nxt;
  logic        o2_vld_r;
  logic [34:0] o2_mag_r;
  den_t        o2_den_r;
  logic        o2_neg_r;

  logic [3:0]  cval;
  logic [35:0] rsum;
  logic [35:0] rsh;
  logic        o3_vld_r;
  logic [32:0] o3_v_r;
  den_t        o3_den_r;
  logic        o3_neg_r;

  logic [33:0] recip;
  logic        o4_vld_r;
  logic [66:0] o4_prod_r;
  den_t        o4_den_r;
  logic        o4_neg_r;

  logic [66:0] qsh;
  logic [31:0] q32;
  logic        o5_vld_r;
  logic [31:0] o5_value_r;

  assign e_nxt = in_side.uflow ? 33'd0 : (in_p >> in_side.n);

  always_comb begin
    e35     = 35'(o1_e_r);
    mag_nxt = '0;
    den_nxt = DEN_1;
    neg_nxt = 1'b0;
    case (o1_side_r.mode)
      MODE_PROB: begin
        den_nxt = DEN_4;
        if (o1_side_r.diag) begin
          mag_nxt = 35'(Q32_ONE) + e35 + (e35 << 1);
        end else begin
          mag_nxt = 35'(Q32_ONE) - e35;
        end
      end
      MODE_DERIV1: begin
        mag_nxt = e35;
        if (o1_side_r.diag) begin
          den_nxt = DEN_1;
          neg_nxt = 1'b1;
        end else begin
          den_nxt = DEN_3;
        end
      end
      MODE_DERIV2: begin
        mag_nxt = e35 << 2;
        if (o1_side_r.diag) begin
          den_nxt = DEN_3;
        end else begin
          den_nxt = DEN_9;
          neg_nxt = 1'b1;
        end
      end
      default: begin
        mag_nxt = '0;
        den_nxt = DEN_1;
        neg_nxt = 1'b0;
      end
    endcase
  end

  // round half up: floor((mag + C*2^(RS-1)) / 2^RS) then floor(. / C)
  always_comb begin
    case (o2_den_r)
      DEN_3:   cval = 4'd3;
      DEN_4:   cval = 4'd4;
      DEN_9:   cval = 4'd9;
      default: cval = 4'd1;
    endcase
    rsum = 36'(o2_mag_r) + (36'(cval) << (RS - 1));
    rsh  = rsum >> RS;
  end

  always_comb begin
    case (o3_den_r)
      DEN_3:   recip = RECIP_3;
      DEN_9:   recip = RECIP_9;
      default: recip = RECIP_1;
    endcase
  end

  always_comb begin
    case (o4_den_r)
      DEN_3:   qsh = o4_prod_r >> 35;
      DEN_4:   qsh = o4_prod_r >> 35;
      DEN_9:   qsh = o4_prod_r >> 37;
      default: qsh = o4_prod_r >> 33;
    endcase
    q32 = qsh[31:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      o1_vld_r <= 1'b0;
      o2_vld_r <= 1'b0;
      o3_vld_r <= 1'b0;
      o4_vld_r <= 1'b0;
      o5_vld_r <= 1'b0;
    end else begin
      o1_vld_r <= in_valid;
      o2_vld_r <= o1_vld_r;
      o3_vld_r <= o2_vld_r;
      o4_vld_r <= o3_vld_r;
      o5_vld_r <= o4_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    o1_side_r  <= in_side;
    o1_e_r     <= e_nxt;
    o2_mag_r   <= mag_nxt;
    o2_den_r   <= den_nxt;
    o2_neg_r   <= neg_nxt;
    o3_v_r     <= rsh[32:0];
    o3_den_r   <= o2_den_r;
    o3_neg_r   <= o2_neg_r;
    o4_prod_r  <= 67'(o3_v_r) * 67'(recip);
    o4_den_r   <= o3_den_r;
    o4_neg_r   <= o3_neg_r;
    o5_value_r <= o4_neg_r ? (32'd0 - q32) : q32;
  end

  assign out_valid = o5_vld_r;
  assign out_value = o5_value_r;

endmodule

`default_nettype wire

// ===== design/jctp_checker.sv =====
// Port-level checks for jukes_cantor_transition_prob, bound to the top level.
// Depends on jctp_pkg.
`default_nettype none

module jctp_checker #(
  parameter int OUT_FRAC_BITS = jctp_pkg::OUT_FRAC_BITS_DEF
) (
  input wire logic                              clk,
  input wire logic                              rst_n,
  input wire logic                              start,
  input wire logic                              busy,
  input wire logic [1:0]                        in_mode,
  input wire logic [1:0]                        in_from_base,
  input wire logic [1:0]                        in_to_base,
  input wire logic [jctp_pkg::DIST_W-1:0]       in_branch_length,
  input wire logic                              out_valid,
  input wire logic signed [jctp_pkg::OUT_W-1:0] out_value
);
  import jctp_pkg::*;

  a_item_returns: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |-> ##PIPE_LATENCY out_valid)
    else $error("accepted item produced no result");

  a_no_phantom: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(start && !busy, PIPE_LATENCY))
    else $error("result without a matching item");

  a_zero_dist_diag: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy && (in_mode == MODE_PROB) && (in_branch_length == '0) &&
     (in_from_base == in_to_base))
    |-> ##PIPE_LATENCY (out_value == 32'(64'd1 << OUT_FRAC_BITS)))
    else $error("zero distance diagonal probability is not one");

  a_unused_mode: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy && (in_mode == MODE_UNUSED)) |-> ##PIPE_LATENCY (out_value == '0))
    else $error("unused mode gave a nonzero value");

endmodule

bind jukes_cantor_transition_prob jctp_checker #(
  .OUT_FRAC_BITS (OUT_FRAC_BITS)
) u_jctp_checker (.*);

`default_nettype wire

// ===== verif/tb.sv =====
// Testbench for jukes_cantor_transition_prob: a directed table, then bursts of
// random items; results are checked against fixed values or an in-bench JC69
// fixed-point predictor. Depends on jctp_pkg and the design sources only.
`timescale 1ns / 1ps

module tb;
  import jctp_pkg::*;

  localparam int DIST_FRAC   = DIST_FRAC_BITS_DEF;
  localparam int OUT_FRAC    = OUT_FRAC_BITS_DEF;
  localparam int RAND_ITEMS  = 1900;
  localparam int MAX_GAP     = 18;
  localparam int IDLE_LIMIT  = 2000;
  // distance where 4/3*d crosses 32*ln2 and e flushes to zero
  localparam int UFLOW_EDGE  = 1090227;

  typedef struct {
    logic [1:0]  mode;
    logic [1:0]  from_b;
    logic [1:0]  to_b;
    logic [23:0] blen;
    bit          fixed;
    logic [31:0] want;
  } stim_row_t;

  logic                    clk;
  logic                    rst_n;
  logic                    start;
  logic                    busy;
  logic [1:0]              in_mode;
  logic [1:0]              in_from_base;
  logic [1:0]              in_to_base;
  logic [DIST_W-1:0]       in_branch_length;
  logic                    out_valid;
  logic signed [OUT_W-1:0] out_value;

  bit                      cur_fixed;
  logic [31:0]             cur_want;
  logic [31:0]             pending_values[$];
  stim_row_t               stim_rows[$];
  int                      errors = 0;
  int                      idle_cycles = 0;

  jukes_cantor_transition_prob dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .start            (start),
    .busy             (busy),
    .in_mode          (in_mode),
    .in_from_base     (in_from_base),
    .in_to_base       (in_to_base),
    .in_branch_length (in_branch_length),
    .out_valid        (out_valid),
    .out_value        (out_value)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // exp(-4/3 d) by ln2 range reduction and Horner, then the mode's fraction
  function automatic logic [31:0] jc_value(logic [1:0] mode, logic [1:0] from_b,
                                           logic [1:0] to_b, logic [23:0] blen);
    logic [63:0] one;
    logic [63:0] ln2;
    logic [63:0] dq;
    logic [63:0] x;
    logic [63:0] n;
    logic [63:0] r;
    logic [63:0] p;
    logic [63:0] k;
    logic [63:0] e;
    logic [63:0] num;
    logic [63:0] den;
    logic [63:0] q;
    bit          neg;
    bit          diag;
    one  = 64'h1_0000_0000;
    ln2  = {32'd0, LN2_Q32};
    dq   = {40'd0, blen} << (32 - DIST_FRAC);
    x    = (dq * 64'd4) / 64'd3;
    n    = x / ln2;
    r    = x - n * ln2;
    p    = one;
    for (k = 64'd12; k >= 64'd1; k--)
      p = one - ((r * p) >> 32) / k;
    e    = (n >= 64'd32) ? 64'd0 : (p >> n);
    diag = (from_b == to_b);
    neg  = 1'b0;
    case (mode)
      MODE_PROB: begin
        num = diag ? one + 64'd3 * e : one - e;
        den = 64'd4;
      end
      MODE_DERIV1: begin
        num = e;
        den = diag ? 64'd1 : 64'd3;
        neg = diag;
      end
      MODE_DERIV2: begin
        num = 64'd4 * e;
        den = diag ? 64'd3 : 64'd9;
        neg = !diag;
      end
      default: begin
        return 32'd0;
      end
    endcase
    den = den << (32 - OUT_FRAC);
    q   = (num + den / 64'd2) / den;
    if (neg) q = 64'd0 - q;
    return q[31:0];
  endfunction

  task automatic flag_mismatch(input string what, input logic [31:0] got,
                               input logic [31:0] want);
    $display("MISMATCH %s: got %h expected %h at %0t", what, got, want, $realtime);
    errors++;
  endtask

  task automatic add_row(input logic [1:0] mode, input logic [1:0] from_b,
                         input logic [1:0] to_b, input logic [23:0] blen,
                         input bit fixed, input logic [31:0] want);
    stim_row_t row;
    row.mode   = mode;
    row.from_b = from_b;
    row.to_b   = to_b;
    row.blen   = blen;
    row.fixed  = fixed;
    row.want   = want;
    stim_rows.push_back(row);
  endtask

  task automatic send_item(input stim_row_t row, input int gap);
    repeat (gap) begin
      @(negedge clk);
      start            <= 1'b0;
      in_mode          <= 2'($urandom);
      in_from_base     <= 2'($urandom);
      in_to_base       <= 2'($urandom);
      in_branch_length <= 24'($urandom);
    end
    @(negedge clk);
    start            <= 1'b1;
    in_mode          <= row.mode;
    in_from_base     <= row.from_b;
    in_to_base       <= row.to_b;
    in_branch_length <= row.blen;
    cur_fixed        <= row.fixed;
    cur_want         <= row.want;
    do @(posedge clk); while (busy);
  endtask

  always @(posedge clk) begin : monitor
    logic [31:0] want;
    bit          moved;
    moved = 1'b0;
    if (rst_n && start && !busy) begin
      pending_values.push_back(cur_fixed ? cur_want :
          jc_value(in_mode, in_from_base, in_to_base, in_branch_length));
      moved = 1'b1;
    end
    if (rst_n && out_valid) begin
      moved = 1'b1;
      if (pending_values.size() == 0) begin
        flag_mismatch("unexpected item", out_value, 32'd0);
      end else begin
        want = pending_values.pop_front();
        if (out_value !== want) flag_mismatch("value", out_value, want);
      end
    end
    idle_cycles = moved ? 0 : idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  initial begin : stimulus
    stim_row_t row;
    int        issued;
    int        burst;
    bit        calm;
    int        pick;
    rst_n            = 1'b0;
    start            = 1'b0;
    in_mode          = MODE_PROB;
    in_from_base     = 2'd0;
    in_to_base       = 2'd0;
    in_branch_length = '0;
    cur_fixed        = 1'b0;
    cur_want         = '0;

    // zero distance, underflow at full range, unused mode, boundary, midpoints
    add_row(MODE_PROB,   2'd0, 2'd0, 24'd0,      1'b1, 32'h4000_0000);
    add_row(MODE_PROB,   2'd1, 2'd2, 24'd0,      1'b1, 32'h0000_0000);
    add_row(MODE_DERIV1, 2'd3, 2'd3, 24'd0,      1'b1, 32'hC000_0000);
    add_row(MODE_DERIV1, 2'd0, 2'd3, 24'd0,      1'b0, 32'd0);
    add_row(MODE_DERIV2, 2'd2, 2'd2, 24'd0,      1'b0, 32'd0);
    add_row(MODE_DERIV2, 2'd1, 2'd0, 24'd0,      1'b0, 32'd0);
    add_row(MODE_UNUSED, 2'd0, 2'd0, 24'd0,      1'b1, 32'h0000_0000);
    add_row(MODE_UNUSED, 2'd1, 2'd2, 24'hFFFFFF, 1'b1, 32'h0000_0000);
    add_row(MODE_PROB,   2'd3, 2'd3, 24'hFFFFFF, 1'b1, 32'h1000_0000);
    add_row(MODE_PROB,   2'd0, 2'd1, 24'hFFFFFF, 1'b1, 32'h1000_0000);
    add_row(MODE_DERIV1, 2'd2, 2'd2, 24'hFFFFFF, 1'b1, 32'h0000_0000);
    add_row(MODE_DERIV1, 2'd2, 2'd1, 24'hFFFFFF, 1'b1, 32'h0000_0000);
    add_row(MODE_DERIV2, 2'd1, 2'd1, 24'hFFFFFF, 1'b1, 32'h0000_0000);
    add_row(MODE_DERIV2, 2'd3, 2'd0, 24'hFFFFFF, 1'b1, 32'h0000_0000);
    add_row(MODE_PROB,   2'd0, 2'd0, 24'd1,      1'b0, 32'd0);
    add_row(MODE_DERIV2, 2'd0, 2'd2, 24'd1,      1'b0, 32'd0);
    add_row(MODE_PROB,   2'd1, 2'd1, 24'(UFLOW_EDGE - 1), 1'b0, 32'd0);
    add_row(MODE_PROB,   2'd1, 2'd1, 24'(UFLOW_EDGE),     1'b0, 32'd0);
    add_row(MODE_DERIV1, 2'd0, 2'd0, 24'(UFLOW_EDGE + 1), 1'b0, 32'd0);
    add_row(MODE_DERIV2, 2'd3, 2'd1, 24'd32768,  1'b0, 32'd0);
    add_row(MODE_PROB,   2'd2, 2'd3, 24'd65536,  1'b0, 32'd0);
    add_row(MODE_DERIV1, 2'd1, 2'd1, 24'h0AAAAA, 1'b0, 32'd0);
    add_row(MODE_DERIV2, 2'd2, 2'd0, 24'h555555, 1'b0, 32'd0);
    add_row(MODE_UNUSED, 2'd3, 2'd3, 24'h800000, 1'b1, 32'h0000_0000);

    repeat (2) @(negedge clk);
    rst_n <= 1'b1;

    foreach (stim_rows[i])
      send_item(stim_rows[i], $urandom_range(0, MAX_GAP));

    issued = 0;
    while (issued < RAND_ITEMS) begin
      burst = $urandom_range(10, 60);
      calm  = ($urandom_range(0, 2) == 0);
      for (int j = 0; j < burst && issued < RAND_ITEMS; j++) begin
        pick = $urandom_range(0, 9);
        row.mode = (pick < 3) ? MODE_PROB : (pick < 6) ? MODE_DERIV1 :
                   (pick < 9) ? MODE_DERIV2 : MODE_UNUSED;
        row.from_b = 2'($urandom);
        row.to_b   = ($urandom_range(0, 1) == 0) ? row.from_b : 2'($urandom);
        pick = $urandom_range(0, 9);
        if (pick < 4)
          row.blen = 24'($urandom_range(0, 24'h0FFFFF));
        else if (pick < 6)
          row.blen = 24'($urandom_range(UFLOW_EDGE - 30, UFLOW_EDGE + 30));
        else if (pick < 8)
          row.blen = 24'($urandom);
        else if (pick < 9)
          row.blen = 24'($urandom_range(0, 64));
        else
          row.blen = 24'($urandom_range(24'hF00000, 24'hFFFFFF));
        row.fixed = 1'b0;
        row.want  = '0;
        send_item(row, calm ? 0 : $urandom_range(0, MAX_GAP));
        issued++;
      end
    end

    @(negedge clk);
    start <= 1'b0;
    while (pending_values.size() != 0) @(posedge clk);
    repeat (PIPE_LATENCY + 4) @(posedge clk);
    if (errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

// ===== files.f =====
design/jctp_pkg.sv
design/jctp_front.sv
design/jctp_range.sv
design/jctp_poly.sv
design/jctp_out.sv
design/jukes_cantor_transition_prob.sv
design/jctp_checker.sv
verif/tb.sv
